@@ hw/rtl/mhcp_pkg.sv @@
// Package for the GF(2) heap column pivot block: request codes and sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package mhcp_pkg;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_PEEK   = 2'd1,
        REQ_POP    = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_RD,    // read parent during sift-up
        ST_UP_CMP,   // compare parent with moving value
        ST_POP_RD,   // read root
        ST_POP_WAIT,
        ST_DN_RD,    // read left child
        ST_DN_RD2,   // read right child, left data arrives
        ST_DN_CMP,   // right data arrives, decide
        ST_TOP_RD,   // read root after a pop
        ST_TOP_CMP,
        ST_DONE
    } state_t;

endpackage

@@ hw/rtl/mod2_heap_column_pivot_top.sv @@
// Sparse GF(2) column held as a max-heap of row indices in one single-port RAM.
// An insert sifts up one level per pass through ST_UP_RD and ST_UP_CMP; a pop sifts down
// one level per pass through ST_DN_RD, ST_DN_RD2 and ST_DN_CMP, and each cancelled pair costs
// two further pops. Peek is a pop followed by an insert. One word is worked on at a time;
// the result register frees the input once the result has been taken.
// Depends on mhcp_pkg and mhcp_ram.
`timescale 1ns / 1ps

module mod2_heap_column_pivot_top
    import mhcp_pkg::*;
#(
    parameter int CAPACITY   = 256,
    parameter int INDEX_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [15:0] s_row_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_pivot_valid,
    output logic [15:0] m_pivot_index,
    output logic [8:0]  m_stored_count,
    output logic        m_overflow
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] pos_reg, pos_next;          // hole position
    logic [INDEX_BITS-1:0] val_reg, val_next;  // moving value
    logic [INDEX_BITS-1:0] lch_reg, lch_next;  // left child value
    logic [INDEX_BITS-1:0] piv_reg, piv_next;  // candidate pivot
    logic [1:0] kind_reg, kind_next;
    logic phase_reg, phase_next;               // popped candidate (1) or its twin (0)
    logic ok_reg, ok_next;
    logic ovf_reg, ovf_next;

    logic we;
    logic [AW-1:0] addr;
    logic [INDEX_BITS-1:0] wdata, rdata;

    logic [CW:0] lidx, ridx;
    assign lidx = {pos_reg, 1'b1} + (CW+1)'(0);
    assign ridx = lidx + (CW+1)'(1);

    mhcp_ram #(.WIDTH(INDEX_BITS), .DEPTH(CAPACITY)) u_ram (
        .aclk(aclk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            m_valid   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (state_reg == ST_DONE) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
        pos_reg <= pos_next;
        val_reg <= val_next;
        lch_reg <= lch_next;
        piv_reg <= piv_next;
        kind_reg <= kind_next;
        phase_reg <= phase_next;
        ok_reg <= ok_next;
        ovf_reg <= ovf_next;
        if (state_reg == ST_DONE) begin
            m_pivot_valid  <= ok_reg;
            m_pivot_index  <= ok_reg ? 16'(piv_reg) : 16'd0;
            m_stored_count <= 9'(cnt_reg);
            m_overflow     <= ovf_reg;
        end
    end

    assign s_ready = (state_reg == ST_IDLE) && !m_valid;

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        pos_next = pos_reg;
        val_next = val_reg;
        lch_next = lch_reg;
        piv_next = piv_reg;
        kind_next = kind_reg;
        phase_next = phase_reg;
        ok_next = ok_reg;
        ovf_next = ovf_reg;
        we = 1'b0;
        addr = pos_reg;
        wdata = val_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    kind_next = s_req_type;
                    ok_next = 1'b0;
                    ovf_next = 1'b0;
                    case (req_t'(s_req_type))
                        REQ_INSERT: begin
                            if (cnt_reg == CW'(CAPACITY)) begin
                                ovf_next = 1'b1;
                                state_next = ST_DONE;
                            end else begin
                                val_next = INDEX_BITS'(s_row_index);
                                pos_next = AW'(cnt_reg);
                                cnt_next = cnt_reg + CW'(1);
                                state_next = ST_UP_RD;
                            end
                        end
                        REQ_CLEAR: begin
                            cnt_next = '0;
                            state_next = ST_DONE;
                        end
                        default: begin
                            phase_next = 1'b1;
                            state_next = (cnt_reg == '0) ? ST_DONE : ST_POP_RD;
                        end
                    endcase
                end
            end
            // Sift-up: the hole at pos moves up while the parent is smaller.
            ST_UP_RD: begin
                if (pos_reg == '0) begin
                    we = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    addr = (pos_reg - AW'(1)) >> 1;
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP: begin
                if (rdata >= val_reg) begin
                    we = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    wdata = rdata;
                    we = 1'b1;
                    pos_next = (pos_reg - AW'(1)) >> 1;
                    state_next = ST_UP_RD;
                end
            end
            // Pop: read root, then last entry becomes the moving value.
            ST_POP_RD: begin
                addr = '0;
                state_next = ST_POP_WAIT;
            end
            ST_POP_WAIT: begin
                if (phase_reg) begin
                    piv_next = rdata;
                end
                addr = AW'(cnt_reg - CW'(1));
                cnt_next = cnt_reg - CW'(1);
                pos_next = '0;
                state_next = ST_DN_RD;
            end
            ST_DN_RD: begin
                if (pos_reg == '0 && lidx == (CW+1)'(1)) begin
                    val_next = rdata;  // last entry arrives
                end
                addr = AW'(lidx);
                state_next = ST_DN_RD2;
            end
            ST_DN_RD2: begin
                lch_next = rdata;
                addr = AW'(ridx);
                state_next = ST_DN_CMP;
            end
            ST_DN_CMP: begin
                if (lidx < (CW+1)'(cnt_reg) && lch_reg > val_reg &&
                    !(ridx < (CW+1)'(cnt_reg) && rdata > lch_reg)) begin
                    wdata = lch_reg;
                    we = 1'b1;
                    pos_next = AW'(lidx);
                    state_next = ST_DN_RD;
                end else if (ridx < (CW+1)'(cnt_reg) && rdata > val_reg) begin
                    wdata = rdata;
                    we = 1'b1;
                    pos_next = AW'(ridx);
                    state_next = ST_DN_RD;
                end else begin
                    we = 1'b1;
                    state_next = ST_TOP_RD;
                end
            end
            ST_TOP_RD: begin
                addr = '0;
                state_next = ST_TOP_CMP;
            end
            ST_TOP_CMP: begin
                if (phase_reg) begin
                    // Candidate popped; a twin on top cancels it.
                    if (cnt_reg != '0 && rdata == piv_reg) begin
                        phase_next = 1'b0;
                        state_next = ST_POP_RD;
                    end else begin
                        ok_next = 1'b1;
                        if (kind_reg == 2'(REQ_PEEK)) begin
                            val_next = piv_reg;
                            pos_next = AW'(cnt_reg);
                            cnt_next = cnt_reg + CW'(1);
                            state_next = ST_UP_RD;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end
                end else begin
                    phase_next = 1'b1;
                    state_next = (cnt_reg == '0) ? ST_DONE : ST_POP_RD;
                end
            end
            ST_DONE: begin
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // The stored count never exceeds the capacity.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(CAPACITY)) else $error("count above capacity");

    // A result only follows the completion state.
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg) == ST_DONE) else $error("stray result");

    // No input is taken while a result is pending.
    a_no_take: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken with result pending");

    // An overflow is only reported with a full heap.
    a_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && ovf_reg) |-> cnt_reg == CW'(CAPACITY))
        else $error("overflow without full heap");

endmodule

@@ hw/rtl/mhcp_ram.sv @@
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module mhcp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
